@@ src/udp_test_frame_generator_top_macros.svh @@
// Assertion macros for the frame generator RTL, used by the beat generator.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef UDP_TEST_FRAME_GENERATOR_TOP_MACROS_SVH
`define UDP_TEST_FRAME_GENERATOR_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define UFG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define UFG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ufg_pkg.sv @@
// Shared types, constants and sizes for the UDP test frame generator.
// No dependencies; every other file but the macro header imports this package.
`timescale 1ns / 1ps

package ufg_pkg;

  // Frame size limits
  localparam int MAX_FRAME_BYTES = 512;
  localparam int MIN_FRAME_BYTES = 60;
  localparam int BEAT_BYTES      = 8;
  localparam int MAX_BEATS       = MAX_FRAME_BYTES / BEAT_BYTES;
  localparam int BEAT_W          = $clog2(MAX_BEATS);
  localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int VB_W            = 4;

  // Field widths
  localparam int CFG_LEN_W   = 10;
  localparam int MAC_W       = 48;
  localparam int IDX_W       = 24;
  localparam int TS_W        = 64;
  localparam int WORD_W      = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 48;
  localparam int SUM_W       = 18;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAC_OVERRIDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_MAC     = 2'd2;

  // Header constants
  localparam logic [47:0] DEFAULT_DMAC  = 48'h000102030405;
  localparam logic [47:0] SRC_MAC       = 48'h060708090A0B;
  localparam logic [15:0] ETHERTYPE_IP  = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL    = 8'h45;
  localparam logic [15:0] IP_ID         = 16'd2012;
  localparam logic [7:0]  IP_TTL        = 8'd64;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
  localparam logic [31:0] IP_SRC_BASE   = 32'h0A000000;
  localparam logic [31:0] IP_DST        = 32'hC0A80001;
  localparam logic [15:0] UDP_SRC_PORT  = 16'd2012;
  localparam logic [15:0] UDP_DST_PORT  = 16'd3000;
  localparam int          ETH_HDR_BYTES = 14;
  localparam int          UDP_OFF_BYTES = 34;

  // Constant part of the IPv4 header sum: fixed words, source base and -14
  localparam int CSUM_CONST = {IP_VER_IHL, 8'h00} + IP_ID + {IP_TTL, IP_PROTO_UDP}
                            + IP_DST[31:16] + IP_DST[15:0] + IP_SRC_BASE[31:16]
                            + IP_SRC_BASE[15:0] - ETH_HDR_BYTES;

  // Header region: bytes 0..55 cover all non-zero content
  localparam int HDR_BEATS = 7;
  localparam int HDR_BITS  = HDR_BEATS * WORD_W;

  typedef struct packed {
    logic [LEN_W-1:0] frame_length;
    logic             mac_override;
    logic [MAC_W-1:0] dest_mac;
  } cfg_t;

  // One queued frame job
  typedef struct packed {
    logic [LEN_W-1:0] frame_length;
    logic [MAC_W-1:0] dest_mac;
    logic [IDX_W-1:0] flow_index;
    logic [TS_W-1:0]  send_timestamp;
    logic [15:0]      ip_csum;
  } desc_t;

endpackage

@@ src/ufg_if.sv @@
// Valid/ready channel interfaces for requests and frame beats.
// Depends on ufg_pkg for field widths.
`timescale 1ns / 1ps

interface ufg_req_if;
  import ufg_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] flow_index;
  logic [TS_W-1:0]  send_timestamp;
  modport source (output valid, output flow_index, output send_timestamp, input ready);
  modport sink   (input valid, input flow_index, input send_timestamp, output ready);
endinterface

interface ufg_beat_if;
  import ufg_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] frame_word;
  logic [VB_W-1:0]   valid_bytes;
  logic              last_beat;
  modport source (output valid, output frame_word, output valid_bytes, output last_beat,
                  input ready);
  modport sink   (input valid, input frame_word, input valid_bytes, input last_beat,
                  output ready);
endinterface

@@ src/ufg_front.sv @@
// Request front end: snapshots config, clamps length, starts the IPv4 sum.
// Depends on ufg_pkg and ufg_if; feeds ufg_queue.
`timescale 1ns / 1ps

module ufg_front (
  input  logic             clk,
  input  logic             rst_n,
  ufg_req_if.sink          in_req,
  input  ufg_pkg::cfg_t    cfg,
  output logic             push,
  output ufg_pkg::desc_t   push_desc,
  input  logic             q_ready
);
  import ufg_pkg::*;

  logic             hold_valid_r, hold_valid_nxt;
  desc_t            hold_desc_r;
  logic [SUM_W-1:0] sum_r;
  logic             accept;
  logic [LEN_W-1:0] len_clamped;
  logic [16:0]      fold1;
  logic [15:0]      fold2;

  // Clamp the configured length into the legal frame range
  always_comb begin
    if (cfg.frame_length < LEN_W'(MIN_FRAME_BYTES)) begin
      len_clamped = LEN_W'(MIN_FRAME_BYTES);
    end else if (cfg.frame_length > LEN_W'(MAX_FRAME_BYTES)) begin
      len_clamped = LEN_W'(MAX_FRAME_BYTES);
    end else begin
      len_clamped = cfg.frame_length;
    end
  end

  assign in_req.ready = !hold_valid_r || q_ready;
  assign accept       = in_req.valid && in_req.ready;
  assign push         = hold_valid_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (q_ready) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  // Capture the request and the raw header sum
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_desc_r.frame_length   <= len_clamped;
      hold_desc_r.dest_mac       <= cfg.mac_override ? cfg.dest_mac : DEFAULT_DMAC;
      hold_desc_r.flow_index     <= in_req.flow_index;
      hold_desc_r.send_timestamp <= in_req.send_timestamp;
      hold_desc_r.ip_csum        <= '0;
      sum_r <= SUM_W'(CSUM_CONST) + SUM_W'(len_clamped)
             + SUM_W'(in_req.flow_index[23:16]) + SUM_W'(in_req.flow_index[15:0]);
    end
  end

  // Fold the end-around carries and invert
  always_comb begin
    fold1     = 17'(sum_r[15:0]) + 17'(sum_r[SUM_W-1:16]);
    fold2     = fold1[15:0] + 16'(fold1[16]);
    push_desc = hold_desc_r;
    push_desc.ip_csum = ~fold2;
  end

endmodule

@@ src/ufg_queue.sv @@
// Two-entry job queue between the front end and the beat generator.
// Depends on ufg_pkg for the job descriptor type.
`timescale 1ns / 1ps

module ufg_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ufg_pkg::desc_t push_desc,
  output logic           push_ready,
  input  logic           pop,
  output logic           pop_valid,
  output ufg_pkg::desc_t pop_desc
);
  import ufg_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  desc_t              entry_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]     count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = (count_r != (PTR_W+1)'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_desc   = entry_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Advance pointers and occupancy; depth is a power of two so pointers wrap
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming job
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

@@ src/ufg_back.sv @@
// Beat generator: builds each 8-byte beat of the frame into an output register.
// Depends on ufg_pkg, ufg_if and the assertion macro header.
`timescale 1ns / 1ps

module ufg_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  ufg_pkg::desc_t q_desc,
  output logic           pop,
  ufg_beat_if.source     out_beat
);
  import ufg_pkg::*;

  `include "udp_test_frame_generator_top_macros.svh"

  logic [BEAT_W-1:0] beat_r, beat_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] word_r;
  logic [VB_W-1:0]   vb_r;
  logic              last_r;
  logic              load;
  logic [LEN_W-1:0]  remain;
  logic              is_last;
  logic [VB_W-1:0]   vb;
  logic [HDR_BITS-1:0] hdr;
  logic [TS_W-1:0]   ts_le;
  logic [WORD_W-1:0] raw_word;
  logic [WORD_W-1:0] word;

  // Byte-swap the timestamp so its low byte goes out first
  always_comb begin
    for (int k = 0; k < TS_W / 8; k++) begin
      ts_le[TS_W-1-8*k -: 8] = q_desc.send_timestamp[8*k +: 8];
    end
  end

  // Lay out the header bytes 0..55
  assign hdr = {q_desc.dest_mac, SRC_MAC, ETHERTYPE_IP,
                IP_VER_IHL, 8'h00, 16'(q_desc.frame_length - LEN_W'(ETH_HDR_BYTES)),
                IP_ID, 16'h0000, IP_TTL, IP_PROTO_UDP, q_desc.ip_csum,
                IP_SRC_BASE + 32'(q_desc.flow_index), IP_DST,
                UDP_SRC_PORT, UDP_DST_PORT,
                16'(q_desc.frame_length - LEN_W'(UDP_OFF_BYTES)), 16'h0000,
                ts_le, 48'h0};

  // Size this beat from the bytes still to send
  always_comb begin
    remain  = q_desc.frame_length - LEN_W'({beat_r, 3'b000});
    is_last = (remain <= LEN_W'(BEAT_BYTES));
    vb      = is_last ? remain[VB_W-1:0] : VB_W'(BEAT_BYTES);
  end

  // Select header slice, zero past the header, mask unused bytes
  always_comb begin
    raw_word = '0;
    for (int k = 0; k < HDR_BEATS; k++) begin
      if (beat_r == BEAT_W'(k)) begin
        raw_word = hdr[HDR_BITS-1-WORD_W*k -: WORD_W];
      end
    end
    for (int i = 0; i < BEAT_BYTES; i++) begin
      word[WORD_W-1-8*i -: 8] = (VB_W'(i) < vb) ? raw_word[WORD_W-1-8*i -: 8] : 8'h00;
    end
  end

  assign load = q_valid && (!out_valid_r || out_beat.ready);
  assign pop  = load && is_last;

  always_comb begin
    beat_nxt      = beat_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      beat_nxt      = is_last ? '0 : beat_r + 1'b1;
    end else if (out_beat.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      beat_r      <= beat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the beat in the output register until taken
  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word;
      vb_r   <= vb;
      last_r <= is_last;
    end
  end

  assign out_beat.valid       = out_valid_r;
  assign out_beat.frame_word  = word_r;
  assign out_beat.valid_bytes = vb_r;
  assign out_beat.last_beat   = last_r;

  `UFG_ASSERT_SAME(a_vb_range, out_valid_r, (vb_r != '0) && (vb_r <= VB_W'(BEAT_BYTES)),
    "beat byte count out of range")
  `UFG_ASSERT_SAME(a_mid_full, out_valid_r && !last_r, vb_r == VB_W'(BEAT_BYTES),
    "partial beat before end of frame")
  `UFG_ASSERT_NEXT(a_beat_restart, pop, beat_r == '0,
    "beat counter not rewound after last beat")

endmodule

@@ src/udp_test_frame_generator_top.sv @@
// Channel          Dir  Fields
// in_req           in   flow_index[23:0], send_timestamp[63:0]
// out_beat         out  frame_word[63:0], valid_bytes[3:0], last_beat
// cfg_we/index     in   cfg_index[1:0], cfg_wdata[47:0]
//
// One beat leaves per cycle when out_beat is ready; a frame of L bytes is
// ceil(L/8) beats (8 to 64), paced by the beat counter in the beat generator.
// Requests are taken back to back while the queue has room; beats are registered.
// A two-entry job queue lets the front end take requests while beats stall.
// Synchronous active-low reset; config regs reset to 60 bytes, no override, MAC 0.
//
// Top level of the UDP test frame generator; depends on ufg_pkg, ufg_if and
// the front, queue and back modules.
`timescale 1ns / 1ps

module udp_test_frame_generator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  ufg_req_if.sink                         in_req,
  ufg_beat_if.source                      out_beat,
  input  logic                            cfg_we,
  input  logic [ufg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ufg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ufg_pkg::*;

  logic [CFG_LEN_W-1:0] len_r;
  logic                 ovr_r;
  logic [MAC_W-1:0]     mac_r;
  cfg_t                 cfg;
  logic                 push, push_ready, pop, q_valid;
  desc_t                push_desc, q_desc;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= CFG_LEN_W'(MIN_FRAME_BYTES);
      ovr_r <= 1'b0;
      mac_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_LENGTH: len_r <= cfg_wdata[CFG_LEN_W-1:0];
        REG_MAC_OVERRIDE: ovr_r <= cfg_wdata[0];
        REG_DEST_MAC:     mac_r <= cfg_wdata[MAC_W-1:0];
        default:          ;
      endcase
    end
  end

  // Clamp the length above the frame limit first; ufg_front applies the floor
  always_comb begin
    if (len_r > CFG_LEN_W'(MAX_FRAME_BYTES)) begin
      cfg.frame_length = LEN_W'(MAX_FRAME_BYTES);
    end else begin
      cfg.frame_length = LEN_W'(len_r);
    end
    cfg.mac_override = ovr_r;
    cfg.dest_mac     = mac_r;
  end

  ufg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg       (cfg),
    .push      (push),
    .push_desc (push_desc),
    .q_ready   (push_ready)
  );

  ufg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (q_valid),
    .pop_desc   (q_desc)
  );

  ufg_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_desc   (q_desc),
    .pop      (pop),
    .out_beat (out_beat)
  );

endmodule

@@ bench/udp_test_frame_generator_top_test.sv @@
// Self-checking bench for the UDP test frame generator top level.
// Depends on ufg_pkg, ufg_if and the RTL; predicts every beat of every frame.
`timescale 1ns / 1ps

module udp_test_frame_generator_top_test;
  import ufg_pkg::*;

  // Register index with no register behind it; writes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Frame header values, independent of the RTL package
  localparam logic [15:0] HDR_ID       = 16'd2012;
  localparam logic [15:0] HDR_SPORT    = 16'd2012;
  localparam logic [15:0] HDR_DPORT    = 16'd3000;
  localparam logic [31:0] HDR_SRC_BASE = 32'h0A000000;
  localparam logic [31:0] HDR_DST_IP   = 32'hC0A80001;
  localparam int          FRAME_FLOOR  = 60;
  localparam int          FRAME_CEIL   = 512;
  localparam int          RANDOM_ITEMS = 400;
  localparam int          MAX_REPORTS  = 50;
  localparam int          LEN_HI_W     = CFG_DATA_W - CFG_LEN_W;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_e;
  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_RARE} stall_mode_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic [IDX_W-1:0]      flow;
    logic [TS_W-1:0]       stamp;
    logic                  typed;
    logic [WORD_W-1:0]     typed_word;
  } stim_row_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [VB_W-1:0]   nbytes;
    logic              last;
  } frame_beat_t;

  localparam int N_ROWS = 31;
  localparam stim_row_t DIRECTED [0:N_ROWS-1] = '{
    // reset settings: 60 bytes, default MAC
    '{ROW_REQ, REG_UNUSED, 48'h0, 24'h000000, 64'h0, 1'b1, 64'h0001020304050607},
    '{ROW_REQ, REG_UNUSED, 48'h0, 24'hFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b1,
      64'h0001020304050607},
    '{ROW_REQ, REG_UNUSED, 48'h0, 24'h123456, 64'h0123456789ABCDEF, 1'b0, 64'h0},
    // short lengths clamp to the floor
    '{ROW_CFG, REG_FRAME_LENGTH, 48'd0, 24'h0, 64'h0, 1'b0, 64'h0},
    '{ROW_REQ, REG_UNUSED, 48'h0, 24'h000001, 64'h1, 1'b0, 64'h0},
    '{ROW_CFG, REG_FRAME_LENGTH, 48'd59, 24'h0, 64'h0, 1'b0, 64'h0},
    '{ROW_REQ, REG_UNUSED, 48'h0, 24'h800000, 64'h8000000000000000, 1'b0, 64'h0},
    // partial and full last beats
    '{ROW_CFG, REG_FRAME_LENGTH, 48'd61, 24'h0, 64'h0, 1'b0, 64'h0},
    '{ROW_REQ, REG_UNUSED, 48'h0, 24'h00FFFF, 64'hFFFFFFFF00000000, 1'b0, 64'h0},
    '{ROW_CFG, REG_FRAME_LENGTH, 48'd64, 24'h0, 64'h0, 1'b0, 64'h0},
    '{ROW_REQ, REG_UNUSED, 48'h0, 24'h7FFFFF, 64'h00000000FFFFFFFF, 1'b0, 64'h0},
    // largest frame and long lengths clamped to the ceiling
    '{ROW_CFG, REG_FRAME_LENGTH, 48'd512, 24'h0, 64'h0, 1'b0, 64'h0},
    '{ROW_REQ, REG_UNUSED, 48'h0, 24'hFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b0, 64'h0},
    '{ROW_CFG, REG_FRAME_LENGTH, 48'd513, 24'h0, 64'h0, 1'b0, 64'h0},
    '{ROW_REQ, REG_UNUSED, 48'h0, 24'h000000, 64'h0, 1'b0, 64'h0},
    '{ROW_CFG, REG_FRAME_LENGTH, 48'd1023, 24'h0, 64'h0, 1'b0, 64'h0},
    '{ROW_REQ, REG_UNUSED, 48'h0, 24'h555555, 64'hAAAAAAAAAAAAAAAA, 1'b0, 64'h0},
    // upper write data bits above the length field are dropped: length 67
    '{ROW_CFG, REG_FRAME_LENGTH, 48'hFFFFFFFFFC43, 24'h0, 64'h0, 1'b0, 64'h0},
    '{ROW_REQ, REG_UNUSED, 48'h0, 24'hAAAAAA, 64'h5555555555555555, 1'b0, 64'h0},
    // destination MAC override
    '{ROW_CFG, REG_DEST_MAC, 48'hFFFFFFFFFFFF, 24'h0, 64'h0, 1'b0, 64'h0},
    '{ROW_CFG, REG_MAC_OVERRIDE, 48'h1, 24'h0, 64'h0, 1'b0, 64'h0},
    '{ROW_REQ, REG_UNUSED, 48'h0, 24'h000000, 64'h0, 1'b1, 64'hFFFFFFFFFFFF0607},
    '{ROW_CFG, REG_DEST_MAC, 48'h0, 24'h0, 64'h0, 1'b0, 64'h0},
    '{ROW_REQ, REG_UNUSED, 48'h0, 24'h000000, 64'h0, 1'b1, 64'h0000000000000607},
    '{ROW_CFG, REG_DEST_MAC, 48'h02A5C3E1F00D, 24'h0, 64'h0, 1'b0, 64'h0},
    '{ROW_REQ, REG_UNUSED, 48'h0, 24'hFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b1,
      64'h02A5C3E1F00D0607},
    // override off through bit 0 only, MAC kept but unused
    '{ROW_CFG, REG_MAC_OVERRIDE, 48'hFFFFFFFFFFFE, 24'h0, 64'h0, 1'b0, 64'h0},
    '{ROW_REQ, REG_UNUSED, 48'h0, 24'h000000, 64'h0, 1'b1, 64'h0001020304050607},
    // write to the unused index changes nothing
    '{ROW_CFG, REG_UNUSED, 48'hFFFFFFFFFFFF, 24'h0, 64'h0, 1'b0, 64'h0},
    '{ROW_REQ, REG_UNUSED, 48'h0, 24'h123456, 64'h00000000CAFEF00D, 1'b1,
      64'h0001020304050607},
    '{ROW_CFG, REG_FRAME_LENGTH, 48'd60, 24'h0, 64'h0, 1'b0, 64'h0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ufg_req_if  req_ch ();
  ufg_beat_if beat_ch ();

  udp_test_frame_generator_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_beat  (beat_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow registers, as written
  logic [CFG_LEN_W-1:0] len_reg;
  logic                 override_reg;
  logic [MAC_W-1:0]     mac_reg;

  frame_beat_t pending_beats [$];
  logic [7:0]  frame_bytes [0:FRAME_CEIL+7];
  int          mismatch_count;
  int          requests_sent;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Count a mismatch; print only the first few
  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  task automatic put16(input int off, input logic [15:0] v);
    frame_bytes[off]     = v[15:8];
    frame_bytes[off + 1] = v[7:0];
  endtask

  // Build the frame from the shadow registers and queue its beats
  task automatic predict_frame(input logic [IDX_W-1:0] flow, input logic [TS_W-1:0] stamp);
    int unsigned       flen;
    int unsigned       nbeats;
    int unsigned       base;
    int unsigned       nvalid;
    int unsigned       sum;
    logic [31:0]       src_ip;
    logic [WORD_W-1:0] word;
    frame_beat_t       beat;
    flen = len_reg;
    if (flen < FRAME_FLOOR) flen = FRAME_FLOOR;
    if (flen > FRAME_CEIL) flen = FRAME_CEIL;
    for (int i = 0; i < FRAME_CEIL + 8; i++) frame_bytes[i] = 8'h00;
    for (int i = 0; i < 12; i++) frame_bytes[i] = i[7:0];
    if (override_reg) begin
      for (int i = 0; i < 6; i++) frame_bytes[i] = mac_reg[47 - 8*i -: 8];
    end
    put16(12, 16'h0800);
    frame_bytes[14] = 8'h45;
    put16(16, 16'(flen - 14));
    put16(18, HDR_ID);
    frame_bytes[22] = 8'd64;
    frame_bytes[23] = 8'd17;
    src_ip = HDR_SRC_BASE + {8'h00, flow};
    put16(26, src_ip[31:16]);
    put16(28, src_ip[15:0]);
    put16(30, HDR_DST_IP[31:16]);
    put16(32, HDR_DST_IP[15:0]);
    // Ones-complement sum over the IPv4 header, fold the carry back in
    sum = 0;
    for (int i = 14; i < 34; i += 2) begin
      sum += {frame_bytes[i], frame_bytes[i + 1]};
      if (sum > 32'hFFFF) sum -= 32'hFFFF;
    end
    put16(24, ~sum[15:0]);
    put16(34, HDR_SPORT);
    put16(36, HDR_DPORT);
    put16(38, 16'(flen - 34));
    for (int i = 0; i < 8; i++) frame_bytes[42 + i] = stamp[8*i +: 8];
    // Slice into beats, zero past the end of the frame
    nbeats = (flen + 7) / 8;
    for (int b = 0; b < nbeats; b++) begin
      base = b * 8;
      nvalid = (flen - base >= 8) ? 8 : flen - base;
      word = '0;
      for (int i = 0; i < 8; i++) begin
        word = {word[55:0], (i < nvalid) ? frame_bytes[base + i] : 8'h00};
      end
      beat.word = word;
      beat.nbytes = VB_W'(nvalid);
      beat.last = (b + 1 == nbeats);
      pending_beats.push_back(beat);
    end
  endtask

  // Write one register and track it in the shadow copy
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    case (idx)
      REG_FRAME_LENGTH: len_reg = data[CFG_LEN_W-1:0];
      REG_MAC_OVERRIDE: override_reg = data[0];
      REG_DEST_MAC:     mac_reg = data[MAC_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offer one request and hold it until the transaction completes
  task automatic send_request(input logic [IDX_W-1:0] flow, input logic [TS_W-1:0] stamp);
    @(negedge clk);
    req_ch.valid = 1'b1;
    req_ch.flow_index = flow;
    req_ch.send_timestamp = stamp;
    do @(posedge clk); while (!req_ch.ready);
    predict_frame(flow, stamp);
    requests_sent++;
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Drop the request and wait until every frame has left the block
  task automatic drain_frames();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver: ready follows a stall mode that changes now and then
  initial begin
    stall_mode_e mode;
    int          tick;
    beat_ch.ready = 1'b0;
    tick = 0;
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk);
        tick++;
        case (mode)
          STALL_NONE:   beat_ch.ready = 1'b1;
          STALL_COIN:   beat_ch.ready = 1'($urandom_range(0, 1));
          STALL_SPARSE: beat_ch.ready = (tick % 4 == 0);
          default:      beat_ch.ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Check each beat transaction against the oldest expectation
  always @(posedge clk) begin
    frame_beat_t want;
    if (rst_n && beat_ch.valid && beat_ch.ready) begin
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h", beat_ch.frame_word));
      end else begin
        want = pending_beats.pop_front();
        if (beat_ch.frame_word !== want.word)
          report_mismatch($sformatf("frame_word %h, want %h", beat_ch.frame_word, want.word));
        if (beat_ch.valid_bytes !== want.nbytes)
          report_mismatch($sformatf("valid_bytes %0d, want %0d", beat_ch.valid_bytes,
                                    want.nbytes));
        if (beat_ch.last_beat !== want.last)
          report_mismatch($sformatf("last_beat %b, want %b", beat_ch.last_beat, want.last));
      end
    end
  end

  // Stimulus
  initial begin
    int          first;
    int          phase_items;
    int          burst_left;
    int          waited;
    int unsigned pick;
    bit          no_gaps;
    logic [IDX_W-1:0] flow;
    logic [TS_W-1:0]  stamp;
    logic [CFG_DATA_W-1:0] len_data;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_FRAME_LENGTH;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.flow_index = '0;
    req_ch.send_timestamp = '0;
    len_reg = CFG_LEN_W'(60);
    override_reg = 1'b0;
    mac_reg = '0;
    mismatch_count = 0;
    requests_sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table; typed rows override the predicted first beat
    for (int r = 0; r < N_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        drain_frames();
        write_reg(DIRECTED[r].reg_idx, DIRECTED[r].reg_data);
      end else begin
        first = pending_beats.size();
        send_request(DIRECTED[r].flow, DIRECTED[r].stamp);
        if (DIRECTED[r].typed) pending_beats[first].word = DIRECTED[r].typed_word;
      end
    end

    // Random phases, each under its own register settings
    requests_sent = 0;
    while (requests_sent < RANDOM_ITEMS) begin
      drain_frames();
      pick = $urandom_range(0, 99);
      if (pick < 60) len_data = CFG_DATA_W'($urandom_range(60, 128));
      else if (pick < 75) len_data = CFG_DATA_W'($urandom_range(129, 511));
      else if (pick < 85) len_data = CFG_DATA_W'(512);
      else if (pick < 92) len_data = CFG_DATA_W'($urandom_range(0, 59));
      else len_data = CFG_DATA_W'($urandom_range(513, 1023));
      len_data[CFG_DATA_W-1:CFG_LEN_W] = LEN_HI_W'({$urandom, $urandom});
      if ($urandom_range(0, 3) == 0) len_data[CFG_DATA_W-1:CFG_LEN_W] = '0;
      write_reg(REG_FRAME_LENGTH, len_data);
      if ($urandom_range(0, 1)) write_reg(REG_MAC_OVERRIDE, CFG_DATA_W'({$urandom, $urandom}));
      if ($urandom_range(0, 1)) write_reg(REG_DEST_MAC, CFG_DATA_W'({$urandom, $urandom}));
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));

      phase_items = $urandom_range(20, 50);
      no_gaps = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 12);
      repeat (phase_items) begin
        flow = IDX_W'($urandom);
        stamp = {$urandom, $urandom};
        pick = $urandom_range(0, 19);
        if (pick == 0) flow = '0;
        else if (pick == 1) flow = '1;
        else if (pick == 2) stamp = '0;
        else if (pick == 3) stamp = '1;
        send_request(flow, stamp);
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          if (!no_gaps) idle_sender($urandom_range(0, 6));
        end
      end
    end

    // Wait for the last frames, with a limit
    @(negedge clk);
    req_ch.valid = 1'b0;
    waited = 0;
    while (pending_beats.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (pending_beats.size() != 0)
      report_mismatch($sformatf("%0d beats never arrived", pending_beats.size()));

    if (mismatch_count == 0) begin
      $display("udp_test_frame_generator_top_test OK");
    end else begin
      $display("udp_test_frame_generator_top_test NOT OK");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin
    #30000000;
    $display("udp_test_frame_generator_top_test NOT OK");
    $finish;
  end

endmodule
